// File: rtl/b64sc_pkg.sv
// Shared types and helper functions for the base64 stream codec.
// Holds the alphabet mapping in both directions and the result-group struct.
// No dependencies.
package b64sc_pkg;

    // Direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Padding character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Up to four result bytes produced by one input item
    typedef struct packed {
        logic            load;      // group holds at least one result
        logic [1:0]      last_idx;  // index of the final byte in the group
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
    } res_group_t;

    // Sextet value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26)
            c = 8'h41 + v8;
        else if (v < 6'd52)
            c = 8'h61 + v8 - 8'd26;
        else if (v < 6'd62)
            c = 8'h30 + v8 - 8'd52;
        else if (v == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

    // Alphabet character to {invalid, sextet}
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = 7'b1000000;
        case (c) inside
            [8'h41:8'h5A]:
            begin
                d = c - 8'h41;
                r = {1'b0, d[5:0]};
            end
            [8'h61:8'h7A]:
            begin
                d = c - 8'h61 + 8'd26;
                r = {1'b0, d[5:0]};
            end
            [8'h30:8'h39]:
            begin
                d = c - 8'h30 + 8'd52;
                r = {1'b0, d[5:0]};
            end
            8'h2B: r = {1'b0, 6'd62};
            8'h2F: r = {1'b0, 6'd63};
            default: r = 7'b1000000;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/b64sc_core.sv
// Input register, group state and the single-pass encode/decode logic.
// Turns one registered input item into a group of up to four result bytes.
// Depends on b64sc_pkg.
module b64sc_core
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       in_has,
    input  logic       in_last,
    input  logic       buf_free,
    output res_group_t res
);

    logic        dir_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  data_reg;
    logic        has_reg;
    logic        last_reg;
    logic [17:0] gbits_reg, gbits_next;
    logic [1:0]  gcount_reg, gcount_next;
    logic        stopped_reg, stopped_next;

    logic        consume;
    logic        accept;
    logic [2:0]  n_res;
    logic [3:0][7:0] bytes;
    logic [17:0] nb;
    logic [6:0]  dec;

    assign consume  = in_valid_reg & buf_free;
    assign in_ready = ~in_valid_reg | buf_free;
    assign accept   = in_valid & in_ready;

    // Input register occupancy
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    // Encode/decode of the held item
    always_comb
    begin
        gbits_next   = gbits_reg;
        gcount_next  = gcount_reg;
        stopped_next = stopped_reg;
        n_res        = 3'd0;
        bytes        = '0;
        nb           = '0;
        dec          = dec_char(data_reg);
        if (dir_reg == DIR_ENCODE)
        begin
            if (has_reg)
            begin
                nb = {2'b00, gbits_reg[7:0], data_reg};
                if (gcount_reg == 2'd2)
                begin
                    bytes[0]    = enc_char(gbits_reg[15:10]);
                    bytes[1]    = enc_char({gbits_reg[9:8], gbits_reg[7:4]});
                    bytes[2]    = enc_char({gbits_reg[3:0], data_reg[7:6]});
                    bytes[3]    = enc_char(data_reg[5:0]);
                    n_res       = 3'd4;
                    gbits_next  = '0;
                    gcount_next = 2'd0;
                end
                else
                begin
                    gbits_next  = nb;
                    gcount_next = gcount_reg + 2'd1;
                end
            end
            // Flush leftovers with padding
            if (last_reg)
            begin
                if (gcount_next == 2'd1)
                begin
                    bytes[0] = enc_char(gbits_next[7:2]);
                    bytes[1] = enc_char({gbits_next[1:0], 4'b0000});
                    bytes[2] = PAD_CHAR;
                    bytes[3] = PAD_CHAR;
                    n_res    = 3'd4;
                end
                else if (gcount_next == 2'd2)
                begin
                    bytes[0] = enc_char(gbits_next[15:10]);
                    bytes[1] = enc_char(gbits_next[9:4]);
                    bytes[2] = enc_char({gbits_next[3:0], 2'b00});
                    bytes[3] = PAD_CHAR;
                    n_res    = 3'd4;
                end
                gbits_next   = '0;
                gcount_next  = 2'd0;
                stopped_next = 1'b0;
            end
        end
        else
        begin
            if (has_reg && !stopped_reg)
            begin
                if (dec[6])
                    stopped_next = 1'b1;
                else
                begin
                    nb = {gbits_reg[11:0], dec[5:0]};
                    if (gcount_reg == 2'd3)
                    begin
                        bytes[0]    = gbits_reg[17:10];
                        bytes[1]    = {gbits_reg[9:2]};
                        bytes[2]    = {gbits_reg[1:0], dec[5:0]};
                        n_res       = 3'd3;
                        gbits_next  = '0;
                        gcount_next = 2'd0;
                    end
                    else
                    begin
                        gbits_next  = nb;
                        gcount_next = gcount_reg + 2'd1;
                    end
                end
            end
            // Flush: n leftover characters give n-1 bytes
            if (last_reg)
            begin
                if (gcount_next == 2'd2)
                begin
                    bytes[0] = gbits_next[11:4];
                    n_res    = 3'd1;
                end
                else if (gcount_next == 2'd3)
                begin
                    bytes[0] = gbits_next[17:10];
                    bytes[1] = gbits_next[9:2];
                    n_res    = 3'd2;
                end
                gbits_next   = '0;
                gcount_next  = 2'd0;
                stopped_next = 1'b0;
            end
        end
    end

    // Result group handed to the serializer
    always_comb
    begin
        res.load     = consume & (n_res != 3'd0);
        res.last_idx = 2'(n_res - 3'd1);
        res.bytes    = bytes;
    end

    // Control and group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg      <= DIR_ENCODE;
            in_valid_reg <= 1'b0;
            gbits_reg    <= '0;
            gcount_reg   <= 2'd0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en)
            begin
                dir_reg     <= cfg_wr_data;
                gbits_reg   <= '0;
                gcount_reg  <= 2'd0;
                stopped_reg <= 1'b0;
            end
            else if (consume)
            begin
                gbits_reg   <= gbits_next;
                gcount_reg  <= gcount_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_data;
            has_reg  <= in_has;
            last_reg <= in_last;
        end
    end

endmodule

// File: rtl/b64sc_serializer.sv
// Result register: holds one group of up to four bytes and sends them one per
// transfer, marking the final byte. Depends on b64sc_pkg.
module b64sc_serializer
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  res_group_t res,
    output logic       buf_free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_data,
    output logic       out_last
);

    logic            valid_reg, valid_next;
    logic [1:0]      idx_reg, idx_next;
    logic [1:0]      last_idx_reg;
    logic [3:0][7:0] bytes_reg;
    logic            fire;

    assign out_valid = valid_reg;
    assign out_data  = bytes_reg[idx_reg];
    assign out_last  = (idx_reg == last_idx_reg);
    assign fire      = valid_reg & out_ready;
    assign buf_free  = ~valid_reg | (fire & out_last);

    // Byte pointer and occupancy
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (res.load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (fire)
        begin
            if (out_last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Group payload
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            bytes_reg    <= res.bytes;
            last_idx_reg <= res.last_idx;
        end
    end

endmodule

// File: rtl/base64_stream_codec_unit.sv
// Top level of the base64 stream codec: input stage with codec logic and the
// output serializer. Depends on b64sc_pkg, b64sc_core and b64sc_serializer.
//
// Base64 codec over the standard alphabet with '=' padding. cfg_wr_data
// selects encoding (0) or decoding (1); a write also clears any partial group
// and is meant for idle periods only. Each input transfer carries one byte in
// s_tdata, a has-byte flag in s_tuser and the end-of-message mark in s_tlast.
// The item is taken into an input register, handled in one pass, and its
// results (none, one to three decoded bytes, or four characters) are loaded
// into a result register that drives one byte per output transfer, with
// m_tlast on the last byte of each item. Every held item, with or without
// results, is processed only when the result register is empty or its last
// byte is being taken, so an item with results holds off the next item until
// its last result byte is taken. On a ready sink encoding gives four
// characters per group, with the output idle while the next group's first
// two bytes are taken in, and decoding gives three bytes per group, with
// the output idle while the next group's characters come in one per cycle.
module base64_stream_codec_unit
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] has_byte
    input  logic       s_tlast,   // msg_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_last
);

    res_group_t res;
    logic       buf_free;

    b64sc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_has     (s_tuser[0]),
        .in_last    (s_tlast),
        .buf_free   (buf_free),
        .res        (res)
    );

    b64sc_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .buf_free (buf_free),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule
